// ----- rtl/olist_pkg.sv -----
// Package for the ordered list engine: command and status codes, cell actions,
// sequencer states and the default capacity. No dependencies.
package olist_pkg;

   localparam int CAPACITY_DEF = 16;

   // Command codes carried in the op field
   typedef enum logic [2:0] {
      OP_INS_FRONT = 3'd0,
      OP_INS_END   = 3'd1,
      OP_INS_AFTER = 3'd2,
      OP_DEL_FRONT = 3'd3,
      OP_DEL_END   = 3'd4,
      OP_DEL_POS   = 3'd5,
      OP_DEL_VAL   = 3'd6,
      OP_DISPLAY   = 3'd7
   } op_type;

   // Status codes carried in result beats
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   // What one cell loads in a cycle
   typedef enum logic [2:0] {
      ACT_HOLD,
      ACT_NEW,
      ACT_LEFT,
      ACT_RIGHT,
      ACT_FIRST
   } cell_act_type;

   typedef struct packed {
      cell_act_type act;
      logic [31:0]  key;
   } cell_ctrl_type;

   // Command sequencer
   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_EXEC,
      S_SHOW
   } state_type;

endpackage

// ----- rtl/ordered_list_engine_top.sv -----
// Ordered list engine: a row of element cells driven by a command sequencer.
// Depends on olist_pkg and olist_cell.
//
// The list holds up to CAPACITY signed 32-bit values in a row of cells; an
// insert or delete shifts every cell behind the edit point by one place, all
// in the same cycle. Each command is captured, compared per cell in S_SCAN
// and applied in S_EXEC, which waits while the result side stalls; a new
// command is taken only once the sequencer is back in S_IDLE. A display
// walks the list by rotating the chain one place per beat and emits one beat
// per element, count beats in all (one beat for an empty list), and the chain
// is back in its original order when the last beat leaves. A command is
// accepted while an earlier result still waits in the output register.
module ordered_list_engine_top
   import olist_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // op[2:0], value[34:3], position[42:35], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // status[1:0], count[6:2], element[38:7], zero pad
   output logic        rsp_tuser,   // element_valid
   output logic        rsp_tlast
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   state_type state_ff, state_in;

   op_type      op_ff;
   logic [31:0] value_ff;
   logic [7:0]  pos_ff;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] show_ff, show_in;

   logic        rsp_valid_ff;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [4:0]  rsp_count_ff, rsp_count_in;
   logic [31:0] rsp_elem_ff, rsp_elem_in;
   logic        rsp_ev_ff, rsp_ev_in;
   logic        rsp_last_ff, rsp_last_in;
   logic        rsp_load;
   logic        rsp_free;

   cell_ctrl_type         ctrl   [CAPACITY];
   cell_act_type          act    [CAPACITY];
   logic [31:0]           cdata  [CAPACITY];
   logic [CAPACITY-1:0]   hit_vec;
   logic [CAPACITY-1:0]   valid_vec;
   logic [CAPACITY-1:0]   del_vec;

   logic       req_fire;
   logic       is_full, is_empty, pos_bad, found;
   logic [8:0] ins_idx;

   assign req_fire = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   // Chain of element cells
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [31:0] left_d, right_d;
      if (g == 0) begin : g_first
         assign left_d = cdata[g];
      end else begin : g_mid_l
         assign left_d = cdata[g-1];
      end
      if (g == CAPACITY - 1) begin : g_end
         assign right_d = cdata[g];
      end else begin : g_mid_r
         assign right_d = cdata[g+1];
      end
      assign ctrl[g].act = act[g];
      assign ctrl[g].key = value_ff;
      olist_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl[g]),
         .left_data  (left_d),
         .right_data (right_d),
         .first_data (cdata[0]),
         .data       (cdata[g]),
         .match      (hit_vec[g])
      );
   end

   // Command conditions from the captured command and the count
   always_comb begin
      is_full  = (count_ff == CNT_W'(CAPACITY));
      is_empty = (count_ff == '0);
      pos_bad  = (pos_ff == 8'd0) || ({1'b0, pos_ff} > 9'(count_ff));
      for (int i = 0; i < CAPACITY; i++) begin
         valid_vec[i] = (9'(i) < 9'(count_ff));
      end
      found = |(hit_vec & valid_vec);
      case (op_ff)
         OP_INS_FRONT: ins_idx = 9'd0;
         OP_INS_END:   ins_idx = 9'(count_ff);
         default:      ins_idx = is_empty ? 9'd0 : {1'b0, pos_ff};
      endcase
      // Cells at or behind the removed element pull from the right
      for (int i = 0; i < CAPACITY; i++) begin
         del_vec[i] = 1'b0;
         case (op_ff)
            OP_DEL_FRONT: del_vec[i] = 1'b1;
            OP_DEL_POS:   del_vec[i] = (9'(i + 1) >= {1'b0, pos_ff});
            OP_DEL_VAL: begin
               for (int j = 0; j < CAPACITY; j++) begin
                  if (j <= i) del_vec[i] = del_vec[i] | (hit_vec[j] & valid_vec[j]);
               end
            end
            default:      del_vec[i] = 1'b0;
         endcase
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (req_fire) state_in = S_SCAN;
         S_SCAN: state_in = S_EXEC;
         S_EXEC: begin
            if (rsp_free) begin
               state_in = (op_ff == OP_DISPLAY && !is_empty) ? S_SHOW : S_IDLE;
            end
         end
         S_SHOW: if (rsp_free && show_ff == CNT_W'(1)) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Cell actions, count update and result beats
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) act[i] = ACT_HOLD;
      count_in      = count_ff;
      show_in       = show_ff;
      rsp_load      = 1'b0;
      rsp_status_in = ST_OK;
      rsp_elem_in   = '0;
      rsp_ev_in     = 1'b0;
      rsp_last_in   = 1'b1;
      case (state_ff)
         S_EXEC: begin
            if (rsp_free) begin
               case (op_ff)
                  OP_INS_FRONT, OP_INS_END, OP_INS_AFTER: begin
                     if (is_full) begin
                        rsp_status_in = ST_FULL;
                     end else if (op_ff == OP_INS_AFTER && !is_empty && pos_bad) begin
                        rsp_status_in = ST_NOT_FOUND;
                     end else begin
                        for (int i = 0; i < CAPACITY; i++) begin
                           if (9'(i) > ins_idx)       act[i] = ACT_LEFT;
                           else if (9'(i) == ins_idx) act[i] = ACT_NEW;
                        end
                        count_in = count_ff + CNT_W'(1);
                     end
                     rsp_load = 1'b1;
                  end
                  OP_DISPLAY: begin
                     if (is_empty) begin
                        rsp_status_in = ST_EMPTY;
                        rsp_load      = 1'b1;
                     end else begin
                        show_in = count_ff;
                     end
                  end
                  default: begin
                     if (is_empty) begin
                        rsp_status_in = ST_EMPTY;
                     end else if (op_ff == OP_DEL_POS && pos_bad) begin
                        rsp_status_in = ST_NOT_FOUND;
                     end else if (op_ff == OP_DEL_VAL && !found) begin
                        rsp_status_in = ST_NOT_FOUND;
                     end else begin
                        for (int i = 0; i < CAPACITY; i++) begin
                           if (del_vec[i]) act[i] = ACT_RIGHT;
                        end
                        count_in = count_ff - CNT_W'(1);
                     end
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end
         S_SHOW: begin
            // Emit the head and rotate the stored elements one place
            if (rsp_free) begin
               rsp_load    = 1'b1;
               rsp_elem_in = cdata[0];
               rsp_ev_in   = 1'b1;
               rsp_last_in = (show_ff == CNT_W'(1));
               show_in     = show_ff - CNT_W'(1);
               for (int i = 0; i < CAPACITY; i++) begin
                  if (9'(i + 1) == 9'(count_ff))    act[i] = ACT_FIRST;
                  else if (9'(i) < 9'(count_ff))    act[i] = ACT_RIGHT;
               end
            end
         end
         default: ;
      endcase
      rsp_count_in = 5'(count_in);
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         show_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         show_ff  <= show_in;
         if (rsp_load)        rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   // Command capture and result payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff    <= op_type'(req_tdata[2:0]);
         value_ff <= req_tdata[34:3];
         pos_ff   <= req_tdata[42:35];
      end
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= rsp_count_in;
         rsp_elem_ff   <= rsp_elem_in;
         rsp_ev_ff     <= rsp_ev_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_elem_ff, rsp_count_ff, rsp_status_ff};
   assign rsp_tuser  = rsp_ev_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Checks
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("element count above capacity");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> (count_ff == $past(count_ff)) ||
                        (count_ff == $past(count_ff) + CNT_W'(1)) ||
                        (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("element count moved by more than one");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast)
      else $error("status beat without last");

   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == S_SCAN)
      else $error("accepted command did not start");

endmodule

// ----- rtl/olist_cell.sv -----
// One storage cell of the list chain: holds one element, loads from its
// neighbors, the first cell or the new value, and registers a compare
// against the search key. Depends on olist_pkg.
module olist_cell
   import olist_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  logic [31:0]   left_data,
   input  logic [31:0]   right_data,
   input  logic [31:0]   first_data,
   output logic [31:0]   data,
   output logic          match
);

   logic [31:0] data_ff, data_in;
   logic        match_ff;

   // Select what the cell takes this cycle
   always_comb begin
      case (ctrl.act)
         ACT_NEW:   data_in = ctrl.key;
         ACT_LEFT:  data_in = left_data;
         ACT_RIGHT: data_in = right_data;
         ACT_FIRST: data_in = first_data;
         default:   data_in = data_ff;
      endcase
   end

   // Store element and compare result
   always_ff @(posedge clock) begin
      data_ff  <= data_in;
      match_ff <= (data_ff == ctrl.key);
   end

   assign data  = data_ff;
   assign match = match_ff;

endmodule

// ----- test/ordered_list_checker.sv -----
`timescale 1ns / 100ps
// Checker for the ordered list engine: watches the command and result streams,
// keeps its own copy of the list and compares every result beat. Depends on olist_pkg.
module ordered_list_checker
   import olist_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,   // op[2:0], value[34:3], position[42:35], zero pad
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // status[1:0], count[6:2], element[38:7], zero pad
   input  logic        rsp_tuser,   // element_valid
   input  logic        rsp_tlast,
   output int          mismatch_count,
   output int          pending_results,
   output int          commands_seen,
   output int          results_checked,
   output int          peak_fill,
   output int          full_refusals
);

   typedef struct packed {
      status_type  status;
      logic [4:0]  count;
      logic [31:0] element;
      logic        element_valid;
      logic        last;
   } list_result_type;

   // Shadow copy of the list, front at index 0
   logic [31:0]     shadow_cells [CAPACITY];
   int              shadow_fill;
   list_result_type results_due [$];

   initial begin
      mismatch_count  = 0;
      pending_results = 0;
      commands_seen   = 0;
      results_checked = 0;
      peak_fill       = 0;
      full_refusals   = 0;
      shadow_fill     = 0;
   end

   function automatic void queue_result(status_type st, logic [31:0] element,
                                        logic valid, logic last);
      list_result_type r;
      r.status        = st;
      r.count         = shadow_fill[4:0];
      r.element       = element;
      r.element_valid = valid;
      r.last          = last;
      results_due.push_back(r);
   endfunction

   // Shift entries at and above idx up one place and place v at idx
   function automatic void open_slot(int idx, logic [31:0] v);
      for (int i = shadow_fill; i > idx; i--) shadow_cells[i] = shadow_cells[i - 1];
      shadow_cells[idx] = v;
      shadow_fill++;
   endfunction

   // Drop the entry at idx and close the gap
   function automatic void close_slot(int idx);
      for (int i = idx; i + 1 < shadow_fill; i++) shadow_cells[i] = shadow_cells[i + 1];
      shadow_fill--;
   endfunction

   // Apply one command to the shadow list and queue the beats it must produce
   function automatic void apply_list_command(op_type op, logic [31:0] value,
                                              logic [7:0] position);
      status_type st;
      int         hit;
      st = ST_OK;
      if (op == OP_DISPLAY) begin
         if (shadow_fill == 0) queue_result(ST_EMPTY, 32'd0, 1'b0, 1'b1);
         for (int i = 0; i < shadow_fill; i++)
            queue_result(ST_OK, shadow_cells[i], 1'b1, i == shadow_fill - 1);
         return;
      end
      case (op)
         OP_INS_FRONT: begin
            if (shadow_fill >= CAPACITY) st = ST_FULL;
            else open_slot(0, value);
         end
         OP_INS_END: begin
            if (shadow_fill >= CAPACITY) st = ST_FULL;
            else open_slot(shadow_fill, value);
         end
         OP_INS_AFTER: begin
            if (shadow_fill >= CAPACITY) st = ST_FULL;
            else if (shadow_fill == 0) open_slot(0, value);
            else if (position == 0 || int'(position) > shadow_fill) st = ST_NOT_FOUND;
            else open_slot(int'(position), value);
         end
         OP_DEL_FRONT: begin
            if (shadow_fill == 0) st = ST_EMPTY;
            else close_slot(0);
         end
         OP_DEL_END: begin
            if (shadow_fill == 0) st = ST_EMPTY;
            else close_slot(shadow_fill - 1);
         end
         OP_DEL_POS: begin
            if (shadow_fill == 0) st = ST_EMPTY;
            else if (position == 0 || int'(position) > shadow_fill) st = ST_NOT_FOUND;
            else close_slot(int'(position) - 1);
         end
         default: begin
            // delete the first element equal to value
            hit = -1;
            for (int i = 0; i < shadow_fill; i++)
               if (hit < 0 && shadow_cells[i] == value) hit = i;
            if (shadow_fill == 0) st = ST_EMPTY;
            else if (hit < 0) st = ST_NOT_FOUND;
            else close_slot(hit);
         end
      endcase
      if (st == ST_FULL) full_refusals++;
      queue_result(st, 32'd0, 1'b0, 1'b1);
   endfunction

   function automatic void report_field(string field, logic [31:0] want, logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: result beat %0d, %s expected %h got %h",
                  $realtime, results_checked, field, want, got);
   endfunction

   // Check result beats first, then predict from the command beat of the same edge
   always @(posedge clock) begin : watch
      list_result_type want;
      if (reset) begin
         shadow_fill = 0;
         results_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (results_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: result beat with nothing expected, data %h user %b last %b",
                           $realtime, rsp_tdata, rsp_tuser, rsp_tlast);
            end else begin
               want = results_due.pop_front();
               if (rsp_tdata[1:0] !== want.status)
                  report_field("status", 32'(want.status), 32'(rsp_tdata[1:0]));
               if (rsp_tdata[6:2] !== want.count)
                  report_field("count", 32'(want.count), 32'(rsp_tdata[6:2]));
               if (rsp_tdata[38:7] !== want.element)
                  report_field("element", want.element, rsp_tdata[38:7]);
               if (rsp_tuser !== want.element_valid)
                  report_field("element_valid", 32'(want.element_valid), 32'(rsp_tuser));
               if (rsp_tlast !== want.last)
                  report_field("last", 32'(want.last), 32'(rsp_tlast));
            end
            results_checked++;
         end
         if (req_tvalid && req_tready) begin
            apply_list_command(op_type'(req_tdata[2:0]), req_tdata[34:3], req_tdata[42:35]);
            commands_seen++;
            if (shadow_fill > peak_fill) peak_fill = shadow_fill;
         end
      end
      pending_results = results_due.size();
   end

endmodule

// ----- test/ordered_list_engine_top_test.sv -----
`timescale 1ns / 100ps
// Top of the ordered list engine testbench: clock, reset, command and result
// stimulus, and the verdict. Depends on olist_pkg, ordered_list_checker and the block.
module ordered_list_engine_top_test;
   import olist_pkg::*;

   localparam int RANDOM_ITEMS  = 300;
   localparam int QUIET_ITEMS   = 40;
   localparam int HOLD_CYCLES   = 120;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int TIME_LIMIT_NS = 600000;

   logic        clock        = 1'b0;
   logic        reset        = 1'b1;
   logic        req_tvalid   = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata    = '0;
   logic        rsp_tvalid;
   logic        rsp_tready   = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        quiet_phase  = 1'b0;
   logic        pressure_req = 1'b0;

   int          mismatch_count;
   int          pending_results;
   int          commands_seen;
   int          results_checked;
   int          peak_fill;
   int          full_refusals;

   logic [31:0] recent_values [$];

   always #1 clock = ~clock;

   ordered_list_engine_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   ordered_list_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results),
      .commands_seen   (commands_seen),
      .results_checked (results_checked),
      .peak_fill       (peak_fill),
      .full_refusals   (full_refusals)
   );

   // Offer one command beat and hold it until taken, then maybe idle a while
   task automatic send_command(input op_type op, input logic [31:0] value,
                               input logic [7:0] position);
      req_tvalid <= 1'b1;
      req_tdata  <= {5'd0, position, value, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (op == OP_INS_FRONT || op == OP_INS_END || op == OP_INS_AFTER) begin
         recent_values.push_back(value);
         if (recent_values.size() > 32) void'(recent_values.pop_front());
      end
      if (!quiet_phase && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   // Grow runs favor inserts, shrink runs favor deletes, mixed runs take any command
   function automatic op_type pick_op(int mode);
      int roll;
      roll = $urandom_range(0, 19);
      if (roll >= 17) return OP_DISPLAY;
      if (mode == 0) return (roll < 13) ? op_type'($urandom_range(0, 2))
                                        : op_type'($urandom_range(3, 6));
      if (mode == 1) return (roll < 13) ? op_type'($urandom_range(3, 6))
                                        : op_type'($urandom_range(0, 2));
      return op_type'($urandom_range(0, 6));
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2, 3, 4: begin
            if (recent_values.size() == 0) return $urandom;
            return recent_values[$urandom_range(0, recent_values.size() - 1)];
         end
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [7:0] pick_position();
      if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(0, 17));
   endfunction

   // Result side: short random stalls, ready stretches, one long hold-off
   initial begin : result_side
      bit held;
      held = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (pressure_req && !held) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   // Command side and verdict
   initial begin : command_side
      int mode;
      int run_left;
      int drain_cycles;
      op_type op;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Every delete and display on an empty list
      send_command(OP_DISPLAY,   32'd0, 8'd0);
      send_command(OP_DEL_FRONT, 32'd0, 8'd1);
      send_command(OP_DEL_END,   32'd0, 8'd1);
      send_command(OP_DEL_POS,   32'd0, 8'd1);
      send_command(OP_DEL_VAL,   32'd5, 8'd0);
      // Insert after a position into an empty list ignores the position
      send_command(OP_INS_AFTER, 32'h7FFF_FFFF, 8'd200);
      send_command(OP_INS_FRONT, 32'h8000_0000, 8'd0);
      send_command(OP_INS_END,   32'hFFFF_FFFF, 8'd0);
      send_command(OP_INS_END,   32'h0000_0000, 8'd0);
      // Positions zero and one past the end are missing
      send_command(OP_INS_AFTER, 32'h1234_5678, 8'd0);
      send_command(OP_INS_AFTER, 32'h1234_5678, 8'd5);
      send_command(OP_INS_AFTER, 32'h5A5A_5A5A, 8'd4);
      send_command(OP_DISPLAY,   32'd0, 8'd0);
      send_command(OP_DEL_POS,   32'd0, 8'd0);
      send_command(OP_DEL_POS,   32'd0, 8'd255);
      send_command(OP_DEL_POS,   32'd0, 8'd2);
      send_command(OP_DEL_VAL,   32'd12345, 8'd0);
      send_command(OP_DEL_VAL,   32'hFFFF_FFFF, 8'd0);
      send_command(OP_DEL_END,   32'd0, 8'd0);
      send_command(OP_DEL_FRONT, 32'd0, 8'd0);
      send_command(OP_DISPLAY,   32'd0, 8'd0);
      // Delete front on a single element empties the list
      send_command(OP_DEL_FRONT, 32'd0, 8'd0);
      send_command(OP_DISPLAY,   32'd0, 8'd0);

      // Random runs that swing the list between empty and full
      run_left = 0;
      mode = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (run_left == 0) begin
            mode = $urandom_range(0, 2);
            run_left = $urandom_range(8, 24);
         end
         run_left--;
         if (n == 60) pressure_req <= 1'b1;
         if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet_phase <= 1'b1;
         op = pick_op(mode);
         send_command(op, pick_value(), pick_position());
      end
      req_tvalid <= 1'b0;

      // Drain what is still in flight
      drain_cycles = 0;
      do begin
         @(negedge clock);
         drain_cycles++;
      end while (pending_results != 0 && drain_cycles < DRAIN_LIMIT);
      repeat (8) @(posedge clock);
      @(negedge clock);

      if (pending_results != 0)
         $display("%0d expected result beats never arrived", pending_results);
      $display("ran %0d commands through %0d checked result beats", commands_seen,
               results_checked);
      $display("list depth peaked at %0d, %0d inserts refused on a full list", peak_fill,
               full_refusals);
      if (mismatch_count == 0 && pending_results == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog
   initial begin : watchdog
      #(TIME_LIMIT_NS);
      $display("timeout with %0d result beats outstanding", pending_results);
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/olist_pkg.sv
rtl/olist_cell.sv
rtl/ordered_list_engine_top.sv
test/ordered_list_checker.sv
test/ordered_list_engine_top_test.sv
